// ----- sv/fse_pkg.sv -----
// ============================================================================
// fse_pkg
// Shared constants and types of the flow statistics extractor.
// ============================================================================
package fse_pkg;

    localparam int MaxPackets = 1048576;
    localparam int FirstCount = 5;
    localparam int CntW       = 21;
    localparam logic [23:0] GapClamp  = 24'hFFFFFF;
    localparam logic [63:0] SizeDevMax = 64'd16777215;
    localparam logic [63:0] GapDevMax  = 64'd2147483647;

    // datapath commands
    typedef struct packed {
        logic       accum;      // add one packet sample
        logic       load;       // latch finish totals for the jobs
        logic [2:0] job;        // which job to start
        logic       start;      // start divider/root on job
        logic       store;      // store job result
        logic       clear;      // clear flow state
    } t_cmd;

    typedef struct packed {
        logic busy;             // divide/root unit working
    } t_sts;

    localparam logic [2:0] JobMeanSize = 3'd0;
    localparam logic [2:0] JobDevSize  = 3'd1;
    localparam logic [2:0] JobMeanGap  = 3'd2;
    localparam logic [2:0] JobDevGap   = 3'd3;
    localparam logic [2:0] JobRatio    = 3'd4;

endpackage

// ----- sv/fse_ctrl.sv -----
// ============================================================================
// fse_ctrl
// Sequencer: accumulates packet requests, walks the finish jobs.
// ============================================================================
module fse_ctrl
    import fse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_req_type,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [2:0] r_job, n_job;
    logic       r_go, n_go;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_go    = 1'b0;
        o_cmd   = '0;
        o_cmd.job = r_job;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_req_type) begin
                        o_cmd.load = 1'b1;
                        n_job   = JobMeanSize;
                        n_go    = 1'b1;
                        n_state = S_RUN;
                    end else begin
                        o_cmd.accum = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_cmd.start = r_go;
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (!i_sts.busy) begin
                    o_cmd.store = 1'b1;
                    if (r_job == JobRatio) begin
                        n_state = S_OUT;
                    end else begin
                        n_job   = r_job + 3'd1;
                        n_go    = 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_job   <= JobMeanSize;
            r_go    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
            r_go    <= n_go;
        end
    end
endmodule

// ----- sv/fse_mul.sv -----
// ============================================================================
// fse_mul
// Sequential 64x64 multiplier, 32x32 partial product per cycle.
// ============================================================================
module fse_mul
    import fse_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_busy,
    output logic [127:0]  o_p
);
    logic [2:0]   r_step;
    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc;
    logic [63:0]  r_pp;
    logic [31:0]  w_x, w_y;
    logic [6:0]   r_sh;

    assign o_busy = (r_step != 3'd0);
    assign o_p    = r_acc;
    assign w_x = r_step[0] ? r_a[31:0] : r_a[63:32];
    assign w_y = r_step[1] ? r_b[63:32] : r_b[31:0];

    // steps 5..2 form a product; the step after adds it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
        end else if (i_start) begin
            r_step <= 3'd5;
        end else if (r_step != 3'd0) begin
            r_step <= r_step - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_pp  <= '0;
            r_sh  <= '0;
        end else if (r_step != 3'd0) begin
            r_acc <= r_acc + ({64'd0, r_pp} << r_sh);
            if (r_step != 3'd1) begin
                // step 5: a0*b0, 4: a1*b0, 3: a0*b1, 2: a1*b1
                r_pp <= (r_step == 3'd5) ? r_a[31:0] * r_b[31:0] :
                        (r_step == 3'd4) ? r_a[63:32] * r_b[31:0] :
                        (r_step == 3'd3) ? r_a[31:0] * r_b[63:32] :
                                           w_x * w_y;
                r_sh <= (r_step == 3'd5) ? 7'd0 :
                        (r_step == 3'd2) ? 7'd64 : 7'd32;
            end else begin
                r_pp <= '0;
            end
        end
    end
endmodule

// ----- sv/fse_dp.sv -----
// ============================================================================
// fse_dp
// Datapath: flow accumulators, shared multiplier, divider and square root.
// ============================================================================
module fse_dp
    import fse_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    input  logic [15:0]  i_pkt_size,
    input  logic [47:0]  i_arrival_us,
    input  logic [47:0]  i_total_in,
    input  logic [47:0]  i_total_out,
    output logic [23:0]  o_mean_size,
    output logic [23:0]  o_dev_size,
    output logic [30:0]  o_mean_gap_ms,
    output logic [30:0]  o_dev_gap_ms,
    output logic [63:0]  o_in_out_ratio,
    output logic [15:0]  o_len_first,
    output logic [15:0]  o_len_second,
    output logic [15:0]  o_len_third,
    output logic [15:0]  o_len_fourth,
    output logic [15:0]  o_len_fifth,
    output logic         o_overflow
);
    // accumulators
    logic [CntW-1:0] r_cnt;
    logic [36:0]     r_s1;
    logic [52:0]     r_s2;
    logic [47:0]     r_prev;
    logic [44:0]     r_g1;
    logic [63:0]     r_g2;
    logic [15:0]     r_first [FirstCount];
    logic            r_ovf;
    logic [47:0]     r_tin, r_tout;

    logic [47:0] w_gap_raw;
    logic [23:0] w_gap;
    logic        w_gap_clip;
    logic [47:0] w_gsq;
    logic [64:0] w_g2sum;
    logic [31:0] w_ssq;

    assign w_gap_raw  = (i_arrival_us >= r_prev) ? i_arrival_us - r_prev : '0;
    assign w_gap_clip = (w_gap_raw > {24'd0, GapClamp});
    assign w_gap      = w_gap_clip ? GapClamp : w_gap_raw[23:0];
    assign w_gsq      = w_gap * w_gap;
    assign w_ssq      = i_pkt_size * i_pkt_size;
    assign w_g2sum    = {1'b0, r_g2} + {17'd0, w_gsq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_cnt  <= '0;
            r_s1   <= '0;
            r_s2   <= '0;
            r_prev <= '0;
            r_g1   <= '0;
            r_g2   <= '0;
            r_ovf  <= 1'b0;
            for (int k = 0; k < FirstCount; k++) r_first[k] <= '0;
        end else if (i_cmd.accum) begin
            if ({11'd0, r_cnt} >= 32'(MaxPackets)) begin
                r_ovf <= 1'b1;
            end else begin
                for (int k = 0; k < FirstCount; k++) begin
                    if ({11'd0, r_cnt} == 32'(k)) r_first[k] <= i_pkt_size;
                end
                r_s1 <= r_s1 + {21'd0, i_pkt_size};
                r_s2 <= r_s2 + {21'd0, w_ssq};
                if (r_cnt != '0) begin
                    r_g1 <= r_g1 + {21'd0, w_gap};
                    if (w_g2sum[64]) begin
                        r_g2 <= '1;
                    end else begin
                        r_g2 <= w_g2sum[63:0];
                    end
                    if (w_g2sum[64] || w_gap_clip) r_ovf <= 1'b1;
                end
                r_prev <= i_arrival_us;
                r_cnt  <= r_cnt + 21'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_tin  <= i_total_in;
            r_tout <= i_total_out;
        end
    end

    // ---------------- job engine ----------------
    // phases: deviation jobs build numerator and divisor in multiply passes; then divide, and for deviations root
    localparam logic [2:0] P_IDLE = 3'd0;
    localparam logic [2:0] P_M1   = 3'd1;   // k*sq
    localparam logic [2:0] P_M2   = 3'd2;   // s*s
    localparam logic [2:0] P_M3   = 3'd3;   // divisor product
    localparam logic [2:0] P_DIV  = 3'd4;
    localparam logic [2:0] P_SQR  = 3'd5;

    logic [2:0]   r_ph;
    logic         r_mgo;
    logic [63:0]  r_ma, r_mb;
    logic         w_mbusy;
    logic [127:0] w_mp;
    logic [127:0] r_num, r_t;
    logic [63:0]  r_den;
    logic [63:0]  r_rem;
    logic [6:0]   r_bit;
    logic [127:0] r_q;
    logic [63:0]  r_x, r_r, r_b;
    logic [63:0]  r_res;
    logic         r_dev, r_skip;
    logic [63:0]  w_m;
    logic [31:0]  w_mk;
    logic         w_mlaunch;
    logic [64:0]  w_rs;
    logic [63:0]  w_rb;

    fse_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mgo),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_busy  (w_mbusy),
        .o_p     (w_mp)
    );

    assign w_m  = {43'd0, r_cnt} - 64'd1;
    // m*1000 stays below 2^30; it is the mean gap divisor, its square the gap deviation divisor
    assign w_mk = {11'd0, w_m[20:0]} * 32'd1000;
    assign w_rs = {r_rem, r_num[127]};
    assign w_rb = r_r + r_b;
    assign o_sts.busy = (r_ph != P_IDLE) || i_cmd.start;

    // launch a multiply pass on a deviation start and after each finished pass but the last
    assign w_mlaunch = i_cmd.start
        ? (((i_cmd.job == JobDevSize) && (r_cnt != '0)) ||
           ((i_cmd.job == JobDevGap) && (r_cnt >= 21'd2)))
        : (((r_ph == P_M1) || (r_ph == P_M2)) && !w_mbusy && !r_mgo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mgo <= 1'b0;
        end else begin
            r_mgo <= w_mlaunch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= P_IDLE;
        end else begin
            if (i_cmd.start) begin
                r_dev  <= (i_cmd.job == JobDevSize) || (i_cmd.job == JobDevGap);
                r_rem  <= '0;
                r_q    <= '0;
                r_bit  <= 7'd127;
                unique case (i_cmd.job)
                    JobMeanSize: begin
                        r_num <= {83'd0, r_s1, 8'd0};
                        r_den <= {43'd0, r_cnt};
                        r_skip <= (r_cnt == '0);
                        r_ph  <= (r_cnt == '0) ? P_IDLE : P_DIV;
                    end
                    JobMeanGap: begin
                        r_num <= {67'd0, r_g1, 16'd0};
                        r_den <= {32'd0, w_mk};
                        r_skip <= (r_cnt < 21'd2);
                        r_ph  <= (r_cnt < 21'd2) ? P_IDLE : P_DIV;
                    end
                    JobRatio: begin
                        if (r_tout != '0) begin
                            r_num <= {64'd0, r_tin, 16'd0};
                            r_den <= {16'd0, r_tout};
                            r_ph  <= P_DIV;
                        end else begin
                            r_skip <= 1'b1;
                            r_res  <= (r_tin != '0) ? {r_tin, 16'd0} : 64'h10000;
                            r_ph   <= P_IDLE;
                        end
                    end
                    JobDevSize: begin
                        r_skip <= (r_cnt == '0);
                        r_ma  <= {43'd0, r_cnt};
                        r_mb  <= {11'd0, r_s2};
                        r_ph  <= (r_cnt == '0) ? P_IDLE : P_M1;
                    end
                    JobDevGap: begin
                        r_skip <= (r_cnt < 21'd2);
                        r_ma  <= w_m;
                        r_mb  <= r_g2;
                        r_ph  <= (r_cnt < 21'd2) ? P_IDLE : P_M1;
                    end
                    default: r_ph <= P_IDLE;
                endcase
            end else begin
                unique case (r_ph)
                    P_M1: if (!w_mbusy && !r_mgo) begin
                        r_t   <= w_mp;
                        r_ma  <= r_dev && (r_cnt != '0) && (i_cmd.job == JobDevSize)
                                 ? {27'd0, r_s1} : {19'd0, r_g1};
                        r_mb  <= (i_cmd.job == JobDevSize) ? {27'd0, r_s1} : {19'd0, r_g1};
                        r_ph  <= P_M2;
                    end
                    P_M2: if (!w_mbusy && !r_mgo) begin
                        r_num <= (r_t >= w_mp) ? r_t - w_mp : '0;
                        if (i_cmd.job == JobDevSize) begin
                            r_ma <= {43'd0, r_cnt};
                            r_mb <= {43'd0, r_cnt};
                        end else begin
                            r_ma <= {32'd0, w_mk};
                            r_mb <= {32'd0, w_mk};
                        end
                        r_ph  <= P_M3;
                    end
                    P_M3: if (!w_mbusy && !r_mgo) begin
                        r_den <= w_mp[63:0];
                        r_num <= (i_cmd.job == JobDevSize) ? r_num << 16 : r_num << 32;
                        r_ph  <= P_DIV;
                    end
                    P_DIV: begin
                        // restoring division, one quotient bit a cycle
                        if (w_rs[64] || w_rs[63:0] >= r_den) begin
                            r_rem <= w_rs[63:0] - r_den;
                            r_q   <= {r_q[126:0], 1'b1};
                        end else begin
                            r_rem <= w_rs[63:0];
                            r_q   <= {r_q[126:0], 1'b0};
                        end
                        r_num <= r_num << 1;
                        r_bit <= r_bit - 7'd1;
                        if (r_bit == 7'd0) begin
                            r_ph <= r_dev ? P_SQR : P_IDLE;
                            r_x  <= {r_q[62:0], (w_rs[64] || w_rs[63:0] >= r_den)};
                            r_r  <= '0;
                            r_b  <= 64'h4000_0000_0000_0000;
                            r_skip <= r_q[126:63] != '0;
                        end
                    end
                    P_SQR: begin
                        // bit-pair square root; saturated quotient skips it
                        if (r_skip || r_b == '0) begin
                            r_ph <= P_IDLE;
                        end else begin
                            if (r_x >= w_rb) begin
                                r_x <= r_x - w_rb;
                                r_r <= (r_r >> 1) + r_b;
                            end else begin
                                r_r <= r_r >> 1;
                            end
                            r_b <= r_b >> 2;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // store: pick the finished result per job
    logic [63:0] w_val;
    always_comb begin
        if (r_dev) begin
            w_val = r_skip ? ((r_ph == P_IDLE && r_b != 64'h4000_0000_0000_0000
                              && r_b != '0) ? '1 : r_r) : r_r;
        end else begin
            w_val = r_q[63:0];
        end
    end

    logic [63:0] r_mean_s, r_dev_s, r_mean_g, r_dev_g, r_ratio;
    logic        r_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sat <= 1'b0;
        end else if (r_ph == P_DIV && r_bit == 7'd0) begin
            r_sat <= r_q[126:63] != '0;
        end
        if (i_cmd.store) begin
            unique case (i_cmd.job)
                JobMeanSize: r_mean_s <= r_skip ? '0 : r_q[63:0];
                JobDevSize:  r_dev_s  <= (r_cnt == '0) ? '0 :
                                         (r_sat || r_r > SizeDevMax) ? SizeDevMax : r_r;
                JobMeanGap:  r_mean_g <= (r_cnt < 21'd2) ? '0 :
                                         (r_q[127:31] != '0) ? GapDevMax : r_q[63:0];
                JobDevGap:   r_dev_g  <= (r_cnt < 21'd2) ? '0 :
                                         (r_sat || r_r > GapDevMax) ? GapDevMax : r_r;
                JobRatio:    r_ratio  <= (r_tout == '0) ? r_res : w_val;
                default: ;
            endcase
        end
    end

    assign o_mean_size    = r_mean_s[23:0];
    assign o_dev_size     = r_dev_s[23:0];
    assign o_mean_gap_ms  = r_mean_g[30:0];
    assign o_dev_gap_ms   = r_dev_g[30:0];
    assign o_in_out_ratio = r_ratio;
    assign o_len_first    = r_first[0];
    assign o_len_second   = r_first[1];
    assign o_len_third    = r_first[2];
    assign o_len_fourth   = r_first[3];
    assign o_len_fifth    = r_first[4];
    assign o_overflow     = r_ovf;
endmodule

// ----- sv/flow_statistics_extractor.sv -----
// ============================================================================
// flow_statistics_extractor
// Per-flow size and gap statistics with mean, deviation and in/out ratio.
// ============================================================================
//  channel | signals                                   | direction
//  request | i_valid/o_ready, i_req_type..i_total_out   | in
//  result  | o_valid/i_ready, o_mean_size..o_overflow    | out
//
//  Packet requests are accepted back to back while idle and never produce a result.
//  A finish request runs five jobs on one shared multiplier, one 128-step
//  restoring divider and a bit-pair square root; the result shows once the
//  last job is stored.
//  Reset is synchronous and clears all flow state; a taken result clears it too.
//  A stalled result holds until i_ready; no request is taken meanwhile.
module flow_statistics_extractor
    import fse_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic         i_req_type,
    input  logic [15:0]  i_pkt_size,
    input  logic [47:0]  i_arrival_us,
    input  logic [47:0]  i_total_in,
    input  logic [47:0]  i_total_out,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [23:0]  o_mean_size,
    output logic [23:0]  o_dev_size,
    output logic [30:0]  o_mean_gap_ms,
    output logic [30:0]  o_dev_gap_ms,
    output logic [63:0]  o_in_out_ratio,
    output logic [15:0]  o_len_first,
    output logic [15:0]  o_len_second,
    output logic [15:0]  o_len_third,
    output logic [15:0]  o_len_fourth,
    output logic [15:0]  o_len_fifth,
    output logic         o_overflow
);
    t_cmd w_cmd;
    t_sts w_sts;

    // sequence the finish jobs
    fse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // hold accumulators and run arithmetic
    fse_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_pkt_size     (i_pkt_size),
        .i_arrival_us   (i_arrival_us),
        .i_total_in     (i_total_in),
        .i_total_out    (i_total_out),
        .o_mean_size    (o_mean_size),
        .o_dev_size     (o_dev_size),
        .o_mean_gap_ms  (o_mean_gap_ms),
        .o_dev_gap_ms   (o_dev_gap_ms),
        .o_in_out_ratio (o_in_out_ratio),
        .o_len_first    (o_len_first),
        .o_len_second   (o_len_second),
        .o_len_third    (o_len_third),
        .o_len_fourth   (o_len_fourth),
        .o_len_fifth    (o_len_fifth),
        .o_overflow     (o_overflow)
    );

`ifndef SYNTHESIS
    // no request is taken while a result is pending
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready during result");
    // accumulate and finish never coincide
    a_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.accum && w_cmd.load)) else $error("accum and load together");
    // a taken result frees the input next cycle
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=> o_ready) else $error("not idle after result");
`endif
endmodule
